// ===== src/ntf_pkg.sv =====
// Shared types, constants and helpers for the normal tangent frame block.
`timescale 1ns / 1ps
`default_nettype none

package ntf_pkg;

    // three 32-bit components, each read as two's complement where signed
    typedef logic [2:0][31:0] vec3_t;

    // one finished result
    typedef struct packed {
        logic  status;
        vec3_t unit_n;
        vec3_t tan_s;
        vec3_t tan_t;
    } res_t;

    localparam logic [31:0] ONE_Q30    = 32'h4000_0000;
    localparam logic [63:0] HALF_Q30   = 64'h0000_0000_2000_0000;
    localparam int          NTF_SIDE_W = 1;

    function automatic logic [31:0] abs32(input logic [31:0] v);
        logic [31:0] r;
        r = v[31] ? (~v + 32'd1) : v;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/ntf_unit3.sv =====
// Pipelined 3-vector normalizer: shift normalize, sum of squares, isqrt, divide, clamp and sign.
`timescale 1ns / 1ps
`default_nettype none

module ntf_unit3 #(
    parameter int SIDE_W = ntf_pkg::NTF_SIDE_W
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  ntf_pkg::vec3_t      in_vec,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output ntf_pkg::vec3_t      out_vec,
    output logic [SIDE_W-1:0]   out_side
);
    import ntf_pkg::*;

    localparam int NORM_ST = 5;
    localparam int SQRT_ST = 32;
    localparam int DIV_ST  = 31;

    // ---------------- magnitude / sign split ----------------
    vec3_t       mag0_next;
    logic [2:0]  neg0_next;
    logic [31:0] or0_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            neg0_next[i] = in_vec[i][31];
            mag0_next[i] = abs32(in_vec[i]);
        end
        or0_next = mag0_next[0] | mag0_next[1] | mag0_next[2];
    end

    logic              nv_reg   [0:NORM_ST];
    vec3_t             nmag_reg [0:NORM_ST];
    logic [31:0]       nor_reg  [0:NORM_ST];
    logic [2:0]        nneg_reg [0:NORM_ST];
    logic [SIDE_W-1:0] nside_reg[0:NORM_ST];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nv_reg[0] <= 1'b0;
        end else if (en) begin
            nv_reg[0]    <= in_valid;
            nmag_reg[0]  <= mag0_next;
            nor_reg[0]   <= or0_next;
            nneg_reg[0]  <= neg0_next;
            nside_reg[0] <= in_side;
        end
    end

    // normalizing shift: bring the largest magnitude to at least 2^30
    for (genvar j = 0; j < NORM_ST; j++) begin : g_norm
        localparam int          STEP = 16 >> j;
        localparam logic [31:0] LIM  = 32'd1 << (31 - STEP);
        logic sh;
        assign sh = nor_reg[j] < LIM;
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                nv_reg[j+1] <= 1'b0;
            end else if (en) begin
                nv_reg[j+1]    <= nv_reg[j];
                nneg_reg[j+1]  <= nneg_reg[j];
                nside_reg[j+1] <= nside_reg[j];
                for (int i = 0; i < 3; i++) begin
                    nmag_reg[j+1][i] <= sh ? (nmag_reg[j][i] << STEP) : nmag_reg[j][i];
                end
                nor_reg[j+1] <= sh ? (nor_reg[j] << STEP) : nor_reg[j];
            end
        end
    end

    // ---------------- squares ----------------
    logic              sqv_reg;
    logic [2:0][63:0]  sq_reg;
    vec3_t             sqmag_reg;
    logic [2:0]        sqneg_reg;
    logic [SIDE_W-1:0] sqside_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sqv_reg <= 1'b0;
        end else if (en) begin
            sqv_reg <= nv_reg[NORM_ST];
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= {32'd0, nmag_reg[NORM_ST][i]} * {32'd0, nmag_reg[NORM_ST][i]};
            end
            sqmag_reg  <= nmag_reg[NORM_ST];
            sqneg_reg  <= nneg_reg[NORM_ST];
            sqside_reg <= nside_reg[NORM_ST];
        end
    end

    // ---------------- integer square root, one root bit per stage ----------------
    logic              qv_reg   [0:SQRT_ST];
    logic [63:0]       qs_reg   [0:SQRT_ST-1];
    logic [32:0]       qrem_reg [0:SQRT_ST-1];
    logic [31:0]       qroot_reg[0:SQRT_ST];
    vec3_t             qmag_reg [0:SQRT_ST];
    logic [2:0]        qneg_reg [0:SQRT_ST];
    logic [SIDE_W-1:0] qside_reg[0:SQRT_ST];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qv_reg[0] <= 1'b0;
        end else if (en) begin
            qv_reg[0]    <= sqv_reg;
            qs_reg[0]    <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            qrem_reg[0]  <= 33'd0;
            qroot_reg[0] <= 32'd0;
            qmag_reg[0]  <= sqmag_reg;
            qneg_reg[0]  <= sqneg_reg;
            qside_reg[0] <= sqside_reg;
        end
    end

    for (genvar i = 0; i < SQRT_ST; i++) begin : g_sqrt
        localparam int B = SQRT_ST - 1 - i;
        logic [34:0] rem2, trial;
        logic        ge;
        assign rem2  = {qrem_reg[i], qs_reg[i][2*B+1:2*B]};
        assign trial = {1'b0, qroot_reg[i], 2'b01};
        assign ge    = rem2 >= trial;
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                qv_reg[i+1] <= 1'b0;
            end else if (en) begin
                qv_reg[i+1]    <= qv_reg[i];
                qroot_reg[i+1] <= {qroot_reg[i][30:0], ge};
                qmag_reg[i+1]  <= qmag_reg[i];
                qneg_reg[i+1]  <= qneg_reg[i];
                qside_reg[i+1] <= qside_reg[i];
            end
        end
        if (i < SQRT_ST - 1) begin : g_pass
            always_ff @(posedge aclk) begin
                if (en) begin
                    qs_reg[i+1]   <= qs_reg[i];
                    qrem_reg[i+1] <= ge ? 33'(rem2 - trial) : rem2[32:0];
                end
            end
        end
    end

    // ---------------- rounded division, one quotient bit per stage ----------------
    logic              dv_reg   [0:DIV_ST];
    logic [2:0][31:0]  drem_reg [0:DIV_ST-1];
    logic [2:0][62:0]  dnum_reg [0:DIV_ST-1];
    logic [31:0]       dlen_reg [0:DIV_ST-1];
    logic [2:0][30:0]  dq_reg   [0:DIV_ST];
    logic [2:0]        dneg_reg [0:DIV_ST];
    logic [SIDE_W-1:0] dside_reg[0:DIV_ST];

    logic [2:0][62:0]  num_next;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            num_next[k] = {1'b0, qmag_reg[SQRT_ST][k], 30'd0}
                        + {32'd0, qroot_reg[SQRT_ST][31:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg[0] <= 1'b0;
        end else if (en) begin
            dv_reg[0]    <= qv_reg[SQRT_ST];
            dlen_reg[0]  <= qroot_reg[SQRT_ST];
            dneg_reg[0]  <= qneg_reg[SQRT_ST];
            dside_reg[0] <= qside_reg[SQRT_ST];
            for (int k = 0; k < 3; k++) begin
                dnum_reg[0][k] <= num_next[k];
                drem_reg[0][k] <= num_next[k][62:31];
                dq_reg[0][k]   <= 31'd0;
            end
        end
    end

    for (genvar i = 0; i < DIV_ST; i++) begin : g_div
        localparam int B = DIV_ST - 1 - i;
        logic [2:0][32:0] r2;
        logic [2:0]       ge;
        always_comb begin
            for (int k = 0; k < 3; k++) begin
                r2[k] = {drem_reg[i][k], dnum_reg[i][k][B]};
                ge[k] = r2[k] >= {1'b0, dlen_reg[i]};
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[i+1] <= 1'b0;
            end else if (en) begin
                dv_reg[i+1]    <= dv_reg[i];
                dneg_reg[i+1]  <= dneg_reg[i];
                dside_reg[i+1] <= dside_reg[i];
                for (int k = 0; k < 3; k++) begin
                    dq_reg[i+1][k] <= dq_reg[i][k] | (31'(ge[k]) << B);
                end
            end
        end
        if (i < DIV_ST - 1) begin : g_pass
            always_ff @(posedge aclk) begin
                if (en) begin
                    dlen_reg[i+1] <= dlen_reg[i];
                    dnum_reg[i+1] <= dnum_reg[i];
                    for (int k = 0; k < 3; k++) begin
                        drem_reg[i+1][k] <= ge[k] ? 32'(r2[k] - {1'b0, dlen_reg[i]})
                                                  : r2[k][31:0];
                    end
                end
            end
        end
    end

    // ---------------- clamp and sign ----------------
    vec3_t out_next;
    logic  ov_reg;
    vec3_t ovec_reg;
    logic [SIDE_W-1:0] oside_reg;

    always_comb begin
        logic [31:0] qe;
        for (int k = 0; k < 3; k++) begin
            qe = {1'b0, dq_reg[DIV_ST][k]};
            if (qe > ONE_Q30) qe = ONE_Q30;
            out_next[k] = dneg_reg[DIV_ST][k] ? (~qe + 32'd1) : qe;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (en) begin
            ov_reg    <= dv_reg[DIV_ST];
            ovec_reg  <= out_next;
            oside_reg <= dside_reg[DIV_ST];
        end
    end

    assign out_valid = ov_reg;
    assign out_vec   = ovec_reg;
    assign out_side  = oside_reg;

endmodule

`default_nettype wire

// ===== src/normal_tangent_frame.sv =====
// Top level: orthonormal frame (unit normal and two tangents) from a Q16.16 normal.
`timescale 1ns / 1ps
`default_nettype none

// Takes one normal per cycle on the s_ request channel while s_ready is
// high and returns one frame per normal on the m_ channel, in order. A
// normal passes the length test (stages A and B), the normalizer for n,
// the axis pick, the normalizer for t, the s products and the output
// register. Most of the depth lies in the two normalizers, each an isqrt
// with one root bit per stage (32 stages) followed by a restoring divider
// with one quotient bit per stage (31 stages). The whole pipeline advances
// on one shared enable; a two-entry output buffer lets the block keep
// taking requests while one finished result waits on m_ready. A normal
// whose squared length is zero or below length_tolerance^2 comes back with
// status 1 and all vectors zero. cfg_data writes length_tolerance (unsigned
// Q16.16, reset raw value 1); write it only when the pipeline is empty.
module normal_tangent_frame (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    // input requests
    input  logic        s_valid,
    output logic        s_ready,
    input  logic signed [31:0] s_normal_x,
    input  logic signed [31:0] s_normal_y,
    input  logic signed [31:0] s_normal_z,
    // results
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_status,
    output logic signed [31:0] m_unit_nx,
    output logic signed [31:0] m_unit_ny,
    output logic signed [31:0] m_unit_nz,
    output logic signed [31:0] m_tan_s_x,
    output logic signed [31:0] m_tan_s_y,
    output logic signed [31:0] m_tan_s_z,
    output logic signed [31:0] m_tan_t_x,
    output logic signed [31:0] m_tan_t_y,
    output logic signed [31:0] m_tan_t_z
);
    import ntf_pkg::*;

    localparam int SIDE2_W = 1 + 96;

    // tolerance register
    logic [31:0] tol_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= 32'd1;
        end else if (cfg_valid) begin
            tol_reg <= cfg_data;
        end
    end

    // Shared pipeline enable: stop only when both output slots are full.
    logic m_valid_reg, spare_v_reg;
    logic en;
    assign en      = !(m_valid_reg && spare_v_reg);
    assign s_ready = en;

    // ---- stage A: squares of the raw components and of the tolerance ----
    logic             a_v_reg;
    logic [2:0][63:0] a_sq_reg;
    logic [63:0]      a_tol2_reg;
    vec3_t            a_n_reg;
    vec3_t            n_in;

    assign n_in = {s_normal_z, s_normal_y, s_normal_x};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
        end else if (en) begin
            a_v_reg <= s_valid;
            for (int i = 0; i < 3; i++) begin
                a_sq_reg[i] <= {32'd0, abs32(n_in[i])} * {32'd0, abs32(n_in[i])};
            end
            a_tol2_reg <= {32'd0, tol_reg} * {32'd0, tol_reg};
            a_n_reg    <= n_in;
        end
    end

    // ---- stage B: exact length test ----
    logic        b_v_reg;
    logic        b_stat_reg;
    vec3_t       b_n_reg;
    logic [63:0] sum_next;

    assign sum_next = a_sq_reg[0] + a_sq_reg[1] + a_sq_reg[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_v_reg <= 1'b0;
        end else if (en) begin
            b_v_reg    <= a_v_reg;
            b_stat_reg <= (sum_next == 64'd0) || (sum_next < a_tol2_reg);
            b_n_reg    <= a_n_reg;
        end
    end

    // ---- normalize n ----
    logic  un_v;
    vec3_t un_vec;
    logic  un_stat;

    ntf_unit3 #(
        .SIDE_W(1)
    ) u_norm_n (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (b_v_reg),
        .in_vec   (b_n_reg),
        .in_side  (b_stat_reg),
        .out_valid(un_v),
        .out_vec  (un_vec),
        .out_side (un_stat)
    );

    // ---- axis pick: smallest |un|, ties to x then y; tr = un x axis ----
    logic  c_v_reg;
    vec3_t c_tr_reg;
    logic [SIDE2_W-1:0] c_side_reg;
    vec3_t tr_next;
    logic [31:0] ax, ay, az;

    always_comb begin
        ax = abs32(un_vec[0]);
        ay = abs32(un_vec[1]);
        az = abs32(un_vec[2]);
        if (ax <= ay && ax <= az) begin
            tr_next[0] = 32'd0;
            tr_next[1] = un_vec[2];
            tr_next[2] = ~un_vec[1] + 32'd1;
        end else if (ay <= az) begin
            tr_next[0] = ~un_vec[2] + 32'd1;
            tr_next[1] = 32'd0;
            tr_next[2] = un_vec[0];
        end else begin
            tr_next[0] = un_vec[1];
            tr_next[1] = ~un_vec[0] + 32'd1;
            tr_next[2] = 32'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_v_reg <= 1'b0;
        end else if (en) begin
            c_v_reg    <= un_v;
            c_tr_reg   <= tr_next;
            c_side_reg <= {un_stat, un_vec};
        end
    end

    // ---- normalize t ----
    logic  t_v;
    vec3_t t_vec;
    logic [SIDE2_W-1:0] t_side;

    ntf_unit3 #(
        .SIDE_W(SIDE2_W)
    ) u_norm_t (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (c_v_reg),
        .in_vec   (c_tr_reg),
        .in_side  (c_side_reg),
        .out_valid(t_v),
        .out_vec  (t_vec),
        .out_side (t_side)
    );

    // ---- s = t x un: six products, Q4.60 ----
    logic                    d_v_reg;
    logic signed [5:0][63:0] d_p_reg;
    logic                    d_stat_reg;
    vec3_t                   d_un_reg;
    vec3_t                   d_t_reg;
    vec3_t                   un2;

    assign un2 = t_side[95:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_v_reg <= 1'b0;
        end else if (en) begin
            d_v_reg    <= t_v;
            d_p_reg[0] <= $signed(t_vec[1]) * $signed(un2[2]);
            d_p_reg[1] <= $signed(t_vec[2]) * $signed(un2[1]);
            d_p_reg[2] <= $signed(t_vec[2]) * $signed(un2[0]);
            d_p_reg[3] <= $signed(t_vec[0]) * $signed(un2[2]);
            d_p_reg[4] <= $signed(t_vec[0]) * $signed(un2[1]);
            d_p_reg[5] <= $signed(t_vec[1]) * $signed(un2[0]);
            d_stat_reg <= t_side[SIDE2_W-1];
            d_un_reg   <= un2;
            d_t_reg    <= t_vec;
        end
    end

    // ---- round s to Q2.30 (halves away from zero, clamp), zero if rejected ----
    res_t        res_next;
    logic [63:0] diff [3];

    always_comb begin
        logic [63:0] mag;
        logic [33:0] q;
        logic [31:0] qc;
        diff[0] = d_p_reg[0] - d_p_reg[1];
        diff[1] = d_p_reg[2] - d_p_reg[3];
        diff[2] = d_p_reg[4] - d_p_reg[5];
        res_next.status = d_stat_reg;
        res_next.unit_n = d_un_reg;
        res_next.tan_t  = d_t_reg;
        for (int i = 0; i < 3; i++) begin
            mag = diff[i][63] ? (~diff[i] + 64'd1) : diff[i];
            q   = 34'((mag + HALF_Q30) >> 30);
            qc  = (q > {2'b00, ONE_Q30}) ? ONE_Q30 : q[31:0];
            res_next.tan_s[i] = diff[i][63] ? (~qc + 32'd1) : qc;
        end
        if (d_stat_reg) begin
            res_next.unit_n = '0;
            res_next.tan_t  = '0;
            res_next.tan_s  = '0;
        end
    end

    // ---- two-entry output buffer ----
    res_t out_reg, spare_reg;
    logic push;
    assign push = en && d_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            spare_v_reg <= 1'b0;
        end else if (m_valid_reg && !m_ready) begin
            if (push) begin
                spare_reg   <= res_next;
                spare_v_reg <= 1'b1;
            end
        end else if (spare_v_reg) begin
            out_reg     <= spare_reg;
            spare_v_reg <= 1'b0;
        end else begin
            out_reg     <= res_next;
            m_valid_reg <= push;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_status  = out_reg.status;
    assign m_unit_nx = out_reg.unit_n[0];
    assign m_unit_ny = out_reg.unit_n[1];
    assign m_unit_nz = out_reg.unit_n[2];
    assign m_tan_s_x = out_reg.tan_s[0];
    assign m_tan_s_y = out_reg.tan_s[1];
    assign m_tan_s_z = out_reg.tan_s[2];
    assign m_tan_t_x = out_reg.tan_t[0];
    assign m_tan_t_y = out_reg.tan_t[1];
    assign m_tan_t_z = out_reg.tan_t[2];

endmodule

`default_nettype wire

// ===== tb/tb_normal_tangent_frame.sv =====
// Self-checking testbench for the normal tangent frame block.
`timescale 1ns / 1ps

module tb_normal_tangent_frame;
    import ntf_pkg::*;

    // pipeline latency, plus margin for draining
    localparam int LATENCY     = 151;
    localparam int DRAIN_WAIT  = LATENCY + 40;
    localparam int WATCHDOG    = 20000;
    localparam int RANDOM_REQS = 900;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    always #5 aclk = ~aclk;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic signed [31:0] s_normal_x = '0, s_normal_y = '0, s_normal_z = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_status;
    logic signed [31:0] m_unit_nx, m_unit_ny, m_unit_nz;
    logic signed [31:0] m_tan_s_x, m_tan_s_y, m_tan_s_z;
    logic signed [31:0] m_tan_t_x, m_tan_t_y, m_tan_t_z;

    normal_tangent_frame DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_normal_x(s_normal_x), .s_normal_y(s_normal_y), .s_normal_z(s_normal_z),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_unit_nx(m_unit_nx), .m_unit_ny(m_unit_ny), .m_unit_nz(m_unit_nz),
        .m_tan_s_x(m_tan_s_x), .m_tan_s_y(m_tan_s_y), .m_tan_s_z(m_tan_s_z),
        .m_tan_t_x(m_tan_t_x), .m_tan_t_y(m_tan_t_y), .m_tan_t_z(m_tan_t_z)
    );

    // frames predicted for accepted requests, oldest first
    res_t        frame_q[$];
    logic [31:0] tol_shadow;     // our copy of length_tolerance
    int          err_count = 0;
    int          idle_cycles = 0;
    bit          quiet_phase = 1'b0;  // no random idling near the end
    bit          hold_off = 1'b0;     // receiver long stall request

    // ---------------- predictor ----------------
    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? -v : v;
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // scale to unit length in Q2.30; zero vector gives zero
    function automatic void normalize(input logic signed [63:0] v[3],
                                      output logic signed [63:0] u[3]);
        logic [63:0] big, ssq, len, a, q;
        logic signed [63:0] w[3];
        int sh;
        big = 0;
        sh = 0;
        for (int i = 0; i < 3; i++) if (mag64(v[i]) > big) big = mag64(v[i]);
        if (big == 0) begin
            for (int i = 0; i < 3; i++) u[i] = 0;
            return;
        end
        while ((big << sh) < 64'(ONE_Q30)) sh++;
        ssq = 0;
        for (int i = 0; i < 3; i++) begin
            w[i] = v[i] <<< sh;
            ssq += mag64(w[i]) * mag64(w[i]);
        end
        len = root_floor(ssq);
        for (int i = 0; i < 3; i++) begin
            a = mag64(w[i]) << 30;
            q = (a + len / 2) / len;
            if (q > 64'(ONE_Q30)) q = 64'(ONE_Q30);
            u[i] = w[i] < 0 ? -$signed(q) : $signed(q);
        end
    endfunction

    function automatic logic [31:0] round_to_q30(input logic signed [63:0] p);
        logic [63:0] q;
        q = (mag64(p) + (64'd1 << 29)) >> 30;
        if (q > 64'(ONE_Q30)) q = 64'(ONE_Q30);
        return p < 0 ? 32'(-$signed(q)) : 32'(q);
    endfunction

    function automatic res_t frame_of(input logic [31:0] x, y, z);
        res_t r;
        logic signed [63:0] n[3], un[3], tr[3], t[3];
        logic [63:0] ssq, tol2, ax, ay, az;
        n[0] = $signed(x); n[1] = $signed(y); n[2] = $signed(z);
        ssq = 0;
        for (int i = 0; i < 3; i++) ssq += mag64(n[i]) * mag64(n[i]);
        tol2 = 64'(tol_shadow) * 64'(tol_shadow);
        r = '0;
        if (ssq == 0 || ssq < tol2) begin
            r.status = 1'b1;
            return r;
        end
        normalize(n, un);
        ax = mag64(un[0]); ay = mag64(un[1]); az = mag64(un[2]);
        if (ax <= ay && ax <= az) begin
            tr[0] = 0; tr[1] = un[2]; tr[2] = -un[1];
        end else if (ay <= az) begin
            tr[0] = -un[2]; tr[1] = 0; tr[2] = un[0];
        end else begin
            tr[0] = un[1]; tr[1] = -un[0]; tr[2] = 0;
        end
        normalize(tr, t);
        for (int i = 0; i < 3; i++) begin
            r.unit_n[i] = un[i][31:0];
            r.tan_t[i]  = t[i][31:0];
        end
        r.tan_s[0] = round_to_q30(t[1] * un[2] - t[2] * un[1]);
        r.tan_s[1] = round_to_q30(t[2] * un[0] - t[0] * un[2]);
        r.tan_s[2] = round_to_q30(t[0] * un[1] - t[1] * un[0]);
        return r;
    endfunction

    // ---------------- checking ----------------
    task automatic report_mismatch(input string what, input logic [31:0] got, exp_v);
        $display("mismatch %s: got %h expected %h at %0t", what, got, exp_v, $realtime);
        err_count++;
    endtask

    always @(posedge aclk) begin
        res_t e;
        if (aresetn && m_valid && m_ready) begin
            if (frame_q.size() == 0) begin
                report_mismatch("unexpected frame", {31'd0, m_status}, 32'd0);
            end else begin
                e = frame_q.pop_front();
                if (m_status !== e.status)
                    report_mismatch("status", {31'd0, m_status}, {31'd0, e.status});
                if (m_unit_nx !== e.unit_n[0]) report_mismatch("unit_nx", m_unit_nx, e.unit_n[0]);
                if (m_unit_ny !== e.unit_n[1]) report_mismatch("unit_ny", m_unit_ny, e.unit_n[1]);
                if (m_unit_nz !== e.unit_n[2]) report_mismatch("unit_nz", m_unit_nz, e.unit_n[2]);
                if (m_tan_s_x !== e.tan_s[0]) report_mismatch("tan_s_x", m_tan_s_x, e.tan_s[0]);
                if (m_tan_s_y !== e.tan_s[1]) report_mismatch("tan_s_y", m_tan_s_y, e.tan_s[1]);
                if (m_tan_s_z !== e.tan_s[2]) report_mismatch("tan_s_z", m_tan_s_z, e.tan_s[2]);
                if (m_tan_t_x !== e.tan_t[0]) report_mismatch("tan_t_x", m_tan_t_x, e.tan_t[0]);
                if (m_tan_t_y !== e.tan_t[1]) report_mismatch("tan_t_y", m_tan_t_y, e.tan_t[1]);
                if (m_tan_t_z !== e.tan_t[2]) report_mismatch("tan_t_z", m_tan_t_z, e.tan_t[2]);
            end
        end
    end

    // Receiver: random stall bursts, or a long hold-off on request.
    always @(posedge aclk) begin
        int gap;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off) begin
            m_ready <= 1'b0;
        end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            m_ready <= 1'b0;
            repeat (gap - 1) @(posedge aclk);
            m_ready <= 1'b1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: cycles with no handshake on any channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    // Offer one request and hold it until accepted; record the expected frame.
    task automatic send_normal(input logic [31:0] x, y, z);
        s_valid    <= 1'b1;
        s_normal_x <= x;
        s_normal_y <= y;
        s_normal_z <= z;
        do @(posedge aclk); while (!s_ready);
        frame_q.push_back(frame_of(x, y, z));
    endtask

    task automatic sender_gap();
        int gap;
        if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic write_tolerance(input logic [31:0] v);
        // stop offering, then let the pipeline empty before touching the register
        s_valid <= 1'b0;
        wait (frame_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        tol_shadow = v;
    endtask

    task automatic random_normal(output logic [31:0] x, y, z);
        int kind;
        kind = $urandom_range(0, 9);
        x = $urandom; y = $urandom; z = $urandom;
        case (kind)
            0: begin  // small magnitudes, near the tolerance
                x = $signed($urandom_range(0, 8)) - 4;
                y = $signed($urandom_range(0, 8)) - 4;
                z = $signed($urandom_range(0, 8)) - 4;
            end
            1: begin  // one axis zero, ties likely
                x = 0;
                z = ($urandom_range(0, 1)) ? y : -y;
            end
            2: begin  // axis-aligned
                y = 0; z = 0;
            end
            3: begin  // medium range
                x = $signed(x) >>> 12; y = $signed(y) >>> 12; z = $signed(z) >>> 12;
            end
            default: ;
        endcase
    endtask

    typedef struct {
        logic [31:0] x, y, z;
        bit          typed;   // expected status typed in
        logic        status;
    } stim_row_t;

    // directed rows: extremes, zero, axes, ties, tolerance boundary
    stim_row_t dir_rows[14] = '{
        '{32'h0, 32'h0, 32'h0, 1, 1'b1},                 // zero normal is rejected
        '{32'h1, 32'h0, 32'h0, 1, 1'b0},                 // exactly the reset tolerance
        '{32'h8000_0000, 32'h0, 32'h0, 0, 1'b0},         // most negative x
        '{32'h0, 32'h7FFF_FFFF, 32'h0, 0, 1'b0},         // most positive y
        '{32'h0, 32'h0, 32'h8000_0000, 0, 1'b0},
        '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 1'b0},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1'b0},  // three-way tie
        '{32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 0, 1'b0},  // x/y tie
        '{32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 0, 1'b0},  // y/z tie
        '{32'h0002_0000, 32'h0003_0000, 32'h0001_0000, 0, 1'b0},  // z smallest
        '{32'hFFFF_0000, 32'h0002_0000, 32'hFFFD_0000, 0, 1'b0},
        '{32'hFFFF_FFFF, 32'h0, 32'h0, 1, 1'b0},
        '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 0, 1'b0},
        '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 0, 1'b0}
    };

    initial begin
        logic [31:0] x, y, z;
        tol_shadow = 32'd1;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows at the reset tolerance
        foreach (dir_rows[i]) begin
            send_normal(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z);
            if (dir_rows[i].typed && frame_q[$].status !== dir_rows[i].status)
                report_mismatch("directed status", {31'd0, frame_q[$].status},
                                {31'd0, dir_rows[i].status});
            sender_gap();
        end
        s_valid <= 1'b0;

        // zero tolerance: anything nonzero passes, zero still fails
        write_tolerance(32'd0);
        send_normal(32'h0, 32'h0, 32'h0);
        if (frame_q[$].status !== 1'b1) report_mismatch("zero at tol 0", 32'd0, 32'd1);
        send_normal(32'h0, 32'h0, 32'h1);
        // boundary around 1.0: length 1.0 passes, just under fails
        write_tolerance(32'h0001_0000);
        send_normal(32'h0001_0000, 32'h0, 32'h0);
        send_normal(32'h0000_FFFF, 32'h0, 32'h0);
        if (frame_q[$].status !== 1'b1) report_mismatch("under tol", 32'd0, 32'd1);
        send_normal(32'h0, 32'hFFFF_0000, 32'h0);
        // largest tolerance: everything is rejected
        write_tolerance(32'hFFFF_FFFF);
        send_normal(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_normal(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        s_valid <= 1'b0;

        // random phases at several tolerances
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: write_tolerance(32'd4);
                1: write_tolerance($urandom_range(0, 32'h0004_0000));
                default: write_tolerance(32'd1);
            endcase
            for (int i = 0; i < RANDOM_REQS / 3; i++) begin
                // long receiver hold-off midway so the pipeline backs up
                if (ph == 1 && i == 50) fork
                    begin
                        hold_off = 1'b1;
                        repeat (400) @(posedge aclk);
                        hold_off = 1'b0;
                    end
                join_none
                if (ph == 2 && i == RANDOM_REQS / 3 - 100) quiet_phase = 1'b1;
                random_normal(x, y, z);
                send_normal(x, y, z);
                sender_gap();
            end
            s_valid <= 1'b0;
        end

        // drain
        fork
            wait (frame_q.size() == 0);
            begin
                repeat (WATCHDOG) @(posedge aclk);
                $display("FAILURE");
                $finish;
            end
        join_any
        disable fork;
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/ntf_pkg.sv
src/ntf_unit3.sv
src/normal_tangent_frame.sv
tb/tb_normal_tangent_frame.sv
